// File: rtl/brlr_pkg.sv
// Shared types and constants of the line rasterizer.
`timescale 1ns / 1ps

package brlr_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int DIM_W     = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef struct packed {
        logic signed [7:0] start_x;
        logic signed [7:0] start_y;
        logic signed [7:0] end_x;
        logic signed [7:0] end_y;
        logic [31:0]       line_color;
    } t_line_cmd;

    typedef struct packed {
        logic [5:0]  pixel_x;
        logic [5:0]  pixel_y;
        logic [11:0] pixel_address;
        logic [31:0] pixel_color;
        logic        visible;
        logic        last;
    } t_pixel_wr;

    typedef struct packed {
        logic load;
        logic advance;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic stall;
        logic at_end;
        logic out_free;
    } t_dp_status;

endpackage

// File: rtl/brlr_ctrl.sv
// Sequencer of the line rasterizer: load, step along the major axis, flush.
`timescale 1ns / 1ps

module brlr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  brlr_pkg::t_dp_status  i_status,
    output brlr_pkg::t_ctrl_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_STEP  = 3'b010,
        S_FINAL = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.advance = !i_status.stall;
                if (!i_status.stall && i_status.at_end) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                o_cmd.finish = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == S_IDLE))
        else $error("load outside idle");

    a_finish_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == S_IDLE))
        else $error("finish did not return to idle");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.advance, o_cmd.finish}))
        else $error("more than one command");

endmodule

// File: rtl/brlr_datapath.sv
// Datapath of the line rasterizer: setup, error term stepping, clip, address, output word.
`timescale 1ns / 1ps

module brlr_datapath #(
    parameter int MAX_DIM = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  brlr_pkg::t_ctrl_cmd                  i_cmd,
    output brlr_pkg::t_dp_status                 o_status,
    input  brlr_pkg::t_line_cmd                  i_in_word,
    input  logic                                 i_cfg_valid,
    input  logic [brlr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [brlr_pkg::DIM_W-1:0]           i_cfg_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output brlr_pkg::t_pixel_wr                  o_out_word
);

    localparam logic [brlr_pkg::DIM_W-1:0] DIM_MAX = brlr_pkg::DIM_W'(MAX_DIM);

    logic [brlr_pkg::DIM_W-1:0] r_width;
    logic [brlr_pkg::DIM_W-1:0] r_height;

    logic              r_steep;
    logic signed [8:0] r_major;
    logic signed [8:0] r_maj1;
    logic signed [8:0] r_minor;
    logic              r_step_neg;
    logic [7:0]        r_dmaj;
    logic [7:0]        r_dmin;
    logic signed [9:0] r_e;
    logic [31:0]       r_color;

    brlr_pkg::t_pixel_wr r_pend;
    logic                r_pend_v;
    brlr_pkg::t_pixel_wr r_out;
    logic                r_out_v;

    // setup
    logic signed [8:0] dx, dy;
    logic [7:0]        adx, ady;
    logic              steep;
    logic signed [7:0] a_maj, a_min, b_maj, b_min;
    logic signed [7:0] maj0, min0, maj1, min1;
    logic              swap;
    logic [8:0]        dmaj_full;

    always_comb begin
        dx    = {i_in_word.end_x[7], i_in_word.end_x}
              - {i_in_word.start_x[7], i_in_word.start_x};
        dy    = {i_in_word.end_y[7], i_in_word.end_y}
              - {i_in_word.start_y[7], i_in_word.start_y};
        adx   = dx[8] ? 8'(-dx) : dx[7:0];
        ady   = dy[8] ? 8'(-dy) : dy[7:0];
        steep = ady > adx;
        a_maj = steep ? i_in_word.start_y : i_in_word.start_x;
        a_min = steep ? i_in_word.start_x : i_in_word.start_y;
        b_maj = steep ? i_in_word.end_y   : i_in_word.end_x;
        b_min = steep ? i_in_word.end_x   : i_in_word.end_y;
        swap  = a_maj > b_maj;
        maj0  = swap ? b_maj : a_maj;
        min0  = swap ? b_min : a_min;
        maj1  = swap ? a_maj : b_maj;
        min1  = swap ? a_min : b_min;
        dmaj_full = {maj1[7], maj1} - {maj0[7], maj0};
    end

    // current pixel, clip and address
    logic [brlr_pkg::DIM_W-1:0] w_eff, h_eff, bound;
    logic signed [8:0]          col, row;
    logic                       hit, beyond;
    logic [12:0]                addr_full;

    always_comb begin
        w_eff  = (r_width  > DIM_MAX) ? DIM_MAX : r_width;
        h_eff  = (r_height > DIM_MAX) ? DIM_MAX : r_height;
        bound  = r_steep ? h_eff : w_eff;
        col    = r_steep ? r_minor : r_major;
        row    = r_steep ? r_major : r_minor;
        hit    = !col[8] && (col[7:0] < {1'b0, w_eff})
              && !row[8] && (row[7:0] < {1'b0, h_eff});
        beyond = !r_major[8] && (r_major[7:0] >= {1'b0, bound});
        addr_full = 13'(row[5:0]) * 13'(w_eff) + 13'(col[5:0]);
    end

    // error term
    logic signed [9:0]  e_sum;
    logic signed [10:0] e_twice, dmaj_ext;
    logic               take_minor;

    always_comb begin
        e_sum      = r_e + $signed({2'b00, r_dmin});
        e_twice    = {e_sum, 1'b0};
        dmaj_ext   = $signed({3'b000, r_dmaj});
        take_minor = e_twice >= dmaj_ext;
    end

    logic out_free;
    assign out_free = !r_out_v || i_out_ready;

    assign o_status.stall    = hit && r_pend_v && !out_free;
    assign o_status.at_end   = (r_major == r_maj1) || beyond;
    assign o_status.out_free = out_free;

    // final word: held pixel or blank, flagged last
    brlr_pkg::t_pixel_wr fin_word;

    always_comb begin
        fin_word      = r_pend_v ? r_pend : '0;
        fin_word.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= brlr_pkg::DIM_RESET;
            r_height <= brlr_pkg::DIM_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                brlr_pkg::CFG_CANVAS_WIDTH:  r_width  <= i_cfg_data;
                brlr_pkg::CFG_CANVAS_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_steep    <= steep;
            r_major    <= {maj0[7], maj0};
            r_maj1     <= {maj1[7], maj1};
            r_minor    <= {min0[7], min0};
            r_step_neg <= min1 < min0;
            r_dmaj     <= dmaj_full[7:0];
            r_dmin     <= steep ? adx : ady;
            r_e        <= '0;
            r_color    <= i_in_word.line_color;
        end else if (i_cmd.advance) begin
            r_major <= r_major + 9'sd1;
            if (take_minor) begin
                r_minor <= r_step_neg ? r_minor - 9'sd1 : r_minor + 9'sd1;
                r_e     <= e_sum - $signed({2'b00, r_dmaj});
            end else begin
                r_e     <= e_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.advance && hit) begin
            r_pend.pixel_x       <= col[5:0];
            r_pend.pixel_y       <= row[5:0];
            r_pend.pixel_address <= addr_full[11:0];
            r_pend.pixel_color   <= r_color;
            r_pend.visible       <= 1'b1;
            r_pend.last          <= 1'b0;
        end
        if (i_cmd.advance && hit && r_pend_v) begin
            r_out <= r_pend;
        end else if (i_cmd.finish) begin
            r_out <= fin_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_pend_v <= 1'b0;
            end else if (i_cmd.advance && hit) begin
                r_pend_v <= 1'b1;
            end
            if ((i_cmd.advance && hit && r_pend_v) || i_cmd.finish) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.advance && hit && r_pend_v) |-> out_free)
        else $error("pending pixel pushed into a full output register");

    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_out_v && r_out.last && !r_pend_v))
        else $error("final word not flagged last");

    a_blank_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.visible) |-> r_out.last)
        else $error("blank word without last");

endmodule

// File: rtl/bresenham_line_rasterizer_unit.sv
// Top level of the Bresenham line rasterizer: sequencer plus datapath.
//
//  channel | direction | handshake                  | word
//  in      | input     | i_in_valid / o_in_ready    | i_in_word   (t_line_cmd)
//  out     | output    | o_out_valid / i_out_ready  | o_out_word  (t_pixel_wr)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A line is set up, then stepped along the major axis from the first endpoint to the
// last one or to the far canvas edge, then flushed; a new line is taken only in idle.
// Each visible pixel is held until the next one, so the last one can carry the last flag.
// A full output register stalls stepping when a held pixel must move to it, and it holds
// back the flush; the config port is always ready.
// Synchronous active-low reset sets both canvas sizes to 64.
`timescale 1ns / 1ps

module bresenham_line_rasterizer_unit #(
    parameter int MAX_DIM = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  brlr_pkg::t_line_cmd             i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output brlr_pkg::t_pixel_wr             o_out_word,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [brlr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [brlr_pkg::DIM_W-1:0]      i_cfg_data
);

    brlr_pkg::t_ctrl_cmd  cmd;
    brlr_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    brlr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    brlr_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
